FILE: rtl/acfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acfb_pkg
// Shared types, constants and functions for the ASCII CRC frame builder.
// ----------------------------------------------------------------------------
package acfb_pkg;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // CRC-16/CCITT-FALSE constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Trailer characters.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    // Input transaction.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       closes_frame;
    } t_in;

    // Output transaction.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_done;
    } t_out;

    // Classified work entry passed from the front to the back.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        closes_frame;
        logic [15:0] crc;
    } t_entry;

    // Write request into the queue.
    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_q_push;

    // Head of the queue as seen by the back part.
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

    // Position within the output sequence of one entry.
    typedef enum logic [3:0] {
        ST_START,
        ST_PAYLOAD,
        ST_SPACE,
        ST_STAR,
        ST_HEX3,
        ST_HEX2,
        ST_HEX1,
        ST_HEX0,
        ST_CR,
        ST_LF
    } t_step;

    // Fold one byte into the CRC, MSB first.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Uppercase ASCII hex digit for one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + {4'h0, nib};
        end else begin
            ch = CH_UPPER_A + {4'h0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/acfb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acfb_front
// Accepts input transactions, keeps the running CRC and queues work entries.
// ----------------------------------------------------------------------------
module acfb_front
    import acfb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_in     i_data,
    input  wire logic    i_q_full,
    output t_q_push      o_q_push
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [15:0] crc_upd;
    logic        accept;

    // The front takes a transaction whenever the queue has room.
    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    // CRC after the payload byte of this transaction, if any.
    always_comb begin
        if (i_data.has_byte) begin
            crc_upd = crc_fold(r_crc, i_data.data_byte);
        end else begin
            crc_upd = r_crc;
        end
        n_crc = r_crc;
        if (accept) begin
            n_crc = i_data.closes_frame ? CRC_INIT : crc_upd;
        end
    end

    // Only transactions that produce output are queued.
    always_comb begin
        o_q_push.push               = accept && (i_data.has_byte || i_data.closes_frame);
        o_q_push.entry.data_byte    = i_data.data_byte;
        o_q_push.entry.has_byte     = i_data.has_byte;
        o_q_push.entry.closes_frame = i_data.closes_frame;
        o_q_push.entry.crc          = crc_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/acfb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acfb_queue
// Small first-in first-out queue of work entries between front and back.
// ----------------------------------------------------------------------------
module acfb_queue
    import acfb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_push i_q_push,
    input  wire logic    i_pop,
    output logic         o_full,
    output t_q_head      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    assign do_push = i_q_push.push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    // Pointer and occupancy update with wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_q_push.entry;
        end
    end

`ifndef NO_ASSERTIONS
    // Occupancy never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy above depth");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_q_push.push)
        else $error("push into full queue");
`endif

endmodule
`default_nettype wire

FILE: rtl/acfb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acfb_back
// Sequences payload and trailer bytes of each entry into the output register.
// ----------------------------------------------------------------------------
module acfb_back
    import acfb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_head i_head,
    output logic         o_pop,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_out         o_data
);

    t_step r_step;
    t_step n_step;
    t_step cur;
    logic  r_out_valid;
    logic  n_out_valid;
    t_out  r_out;
    t_out  n_out;
    logic  out_free;
    logic  emit;
    logic  last;

    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign out_free = !r_out_valid || i_ready;
    assign emit     = i_head.valid && out_free;

    // Step selection, byte generation and pop of the finished entry.
    always_comb begin
        if (r_step == ST_START) begin
            cur = i_head.entry.has_byte ? ST_PAYLOAD : ST_SPACE;
        end else begin
            cur = r_step;
        end

        n_out.frame_done = (cur == ST_LF);
        case (cur)
            ST_PAYLOAD: n_out.out_byte = i_head.entry.data_byte;
            ST_SPACE:   n_out.out_byte = CH_SPACE;
            ST_STAR:    n_out.out_byte = CH_STAR;
            ST_HEX3:    n_out.out_byte = hex_char(i_head.entry.crc[15:12]);
            ST_HEX2:    n_out.out_byte = hex_char(i_head.entry.crc[11:8]);
            ST_HEX1:    n_out.out_byte = hex_char(i_head.entry.crc[7:4]);
            ST_HEX0:    n_out.out_byte = hex_char(i_head.entry.crc[3:0]);
            ST_CR:      n_out.out_byte = CH_CR;
            ST_LF:      n_out.out_byte = CH_LF;
            default:    n_out.out_byte = CH_SPACE;
        endcase

        last = ((cur == ST_PAYLOAD) && !i_head.entry.closes_frame) || (cur == ST_LF);

        n_step = r_step;
        if (emit) begin
            if (last) begin
                n_step = ST_START;
            end else begin
                case (cur)
                    ST_PAYLOAD: n_step = ST_SPACE;
                    ST_SPACE:   n_step = ST_STAR;
                    ST_STAR:    n_step = ST_HEX3;
                    ST_HEX3:    n_step = ST_HEX2;
                    ST_HEX2:    n_step = ST_HEX1;
                    ST_HEX1:    n_step = ST_HEX0;
                    ST_HEX0:    n_step = ST_CR;
                    ST_CR:      n_step = ST_LF;
                    default:    n_step = ST_START;
                endcase
            end
        end

        o_pop = emit && last;

        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_START;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    // Frame end is only ever flagged on a line feed.
    a_done_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_done) |-> (r_out.out_byte == CH_LF))
        else $error("frame_done without line feed");

    // Loading a line feed finishes the entry and returns to the start step.
    a_lf_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (cur == ST_LF)) |=> (r_step == ST_START))
        else $error("sequence did not restart after line feed");
`endif

endmodule
`default_nettype wire

FILE: rtl/ascii_crc_frame_builder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_crc_frame_builder_top
// Passes payload bytes through and closes frames with a CRC-16 text trailer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_data) carries one transaction per
//   accepted cycle: an optional payload byte and a close-frame flag.
//   Output channel (o_valid / i_ready / o_data) carries one byte per
//   transaction; frame_done marks the LF that ends a frame trailer.
//   A closing transaction yields " *", four uppercase hex CRC digits, CR, LF.
// Path: with the queue empty and the output free, an accepted transaction is
//   written into the queue, and its first output byte is then loaded into
//   the output register.
// Throughput: one payload byte per cycle while the output is not stalled.
//   A closing transaction holds the sequencer for its payload byte, if any,
//   and its eight trailer bytes; a 4-entry queue (QUEUE_DEPTH) lets input
//   keep flowing meanwhile, and o_ready drops only when that queue is full.
// Reset: synchronous, active low; the CRC returns to 0xFFFF, the queue
//   empties and no output is valid.
// Stall: while i_ready is low the output register holds its byte; the
//   sequencer waits and the queue fills behind it.
// ----------------------------------------------------------------------------
module ascii_crc_frame_builder_top
    import acfb_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    t_q_push q_push;
    t_q_head q_head;
    logic    q_full;
    logic    q_pop;

    // Front: acceptance and CRC.
    acfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_q_push (q_push)
    );

    // Decoupling queue.
    acfb_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_push (q_push),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_head   (q_head)
    );

    // Back: byte sequencing and output register.
    acfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

FILE: test/tb_ascii_crc_frame_builder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_crc_frame_builder_top
// Self-checking bench for the ASCII CRC frame builder. A short table of
// directed transactions, some with hand-written expected bytes, is followed
// by random frames. Every output byte is checked against the hand-written bytes
// or a bit-serial CRC-16 frame predictor, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_ascii_crc_frame_builder_top;
    import acfb_pkg::*;

    localparam int RANDOM_ITEMS   = 128;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_PRINTED    = 40;

    // One row of the directed table; golden is used only when typed is set.
    typedef struct {
        t_in   item;
        bit    typed;
        string golden;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    // Predictor state and the bytes still to arrive.
    logic [15:0] model_crc = CRC_INIT;
    t_out        pending_bytes_q[$];
    bit          typed_q[$];
    string       golden_q[$];
    t_stim_row   directed_rows[$];

    int mismatch_cnt = 0;
    int idle_cycles  = 0;
    bit quiet        = 1'b0;
    bit hold_req     = 1'b0;

    ascii_crc_frame_builder_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Clock with a 20 ns period.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what);
        if (mismatch_cnt < MAX_PRINTED) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        mismatch_cnt++;
    endtask

    // Fold one byte into a CRC, feeding the data bits one at a time.
    function automatic logic [15:0] fold_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Uppercase ASCII digit for one nibble.
    function automatic logic [7:0] ascii_nibble(input logic [3:0] n);
        return (n > 4'd9) ? (CH_UPPER_A + {4'h0, n} - 8'd10) : (CH_ZERO + {4'h0, n});
    endfunction

    // Predict the output bytes of one transaction and advance the model CRC.
    task automatic build_frame_bytes(input t_in it, ref t_out res[$]);
        t_out       b;
        logic [7:0] trailer [8];
        res.delete();
        if (it.has_byte) begin
            b.out_byte   = it.data_byte;
            b.frame_done = 1'b0;
            res.push_back(b);
            model_crc = fold_crc_byte(model_crc, it.data_byte);
        end
        if (it.closes_frame) begin
            trailer = '{CH_SPACE, CH_STAR,
                        ascii_nibble(model_crc[15:12]), ascii_nibble(model_crc[11:8]),
                        ascii_nibble(model_crc[7:4]), ascii_nibble(model_crc[3:0]),
                        CH_CR, CH_LF};
            for (int k = 0; k < 8; k++) begin
                b.out_byte   = trailer[k];
                b.frame_done = (k == 7);
                res.push_back(b);
            end
            model_crc = CRC_INIT;
        end
    endtask

    function automatic void add_row(input logic [7:0] d, input bit h, input bit c,
                                    input bit typed, input string g);
        t_stim_row row;
        row.item.data_byte    = d;
        row.item.has_byte     = h;
        row.item.closes_frame = c;
        row.typed             = typed;
        row.golden            = g;
        directed_rows.push_back(row);
    endfunction

    function automatic t_in random_item();
        t_in it;
        int  r;
        r = $urandom_range(0, 99);
        it.data_byte = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                    : 8'($urandom);
        it.has_byte     = (r >= 14);
        it.closes_frame = (r >= 8 && r < 26);
        return it;
    endfunction

    // Offer one transaction and hold it until the block accepts it.
    task automatic offer_item(input t_in it, input bit typed, input string g);
        typed_q.push_back(typed);
        golden_q.push_back(g);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!(i_valid && o_ready));
    endtask

    // Random idle gap on the input side, with i_valid low.
    task automatic idle_gap();
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 12);
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_data  <= t_in'($urandom);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Output side: random stall bursts, and one long hold-off on request.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on each input transaction, check each output
    // transaction, and watch for a stuck handshake.
    always @(posedge i_clk) begin
        t_out  model_out[$];
        t_out  want;
        string g;
        bit    typed;
        bit    active;
        active = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                active = 1'b1;
                typed  = typed_q.pop_front();
                g      = golden_q.pop_front();
                build_frame_bytes(i_data, model_out);
                // A typed row replaces the predicted bytes with the written ones.
                if (typed) begin
                    model_out.delete();
                    for (int k = 0; k < g.len(); k++) begin
                        want.out_byte   = g[k];
                        want.frame_done = (k == g.len() - 1) && i_data.closes_frame;
                        model_out.push_back(want);
                    end
                end
                foreach (model_out[k]) pending_bytes_q.push_back(model_out[k]);
            end
            if (o_valid && i_ready) begin
                active = 1'b1;
                if (pending_bytes_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", o_data.out_byte));
                end else begin
                    want = pending_bytes_q.pop_front();
                    if (o_data.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                                  o_data.out_byte, want.out_byte));
                    end
                    if (o_data.frame_done !== want.frame_done) begin
                        report_mismatch($sformatf("frame_done got %b want %b on byte %02h",
                                                  o_data.frame_done, want.frame_done,
                                                  want.out_byte));
                    end
                end
            end
            if (active) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("tb_ascii_crc_frame_builder_top NOT OK");
                    $finish;
                end
            end
        end
    end

    // Stimulus.
    initial begin
        t_in it;
        int  n_real;
        int  burst_left;
        bit  hold_done;
        bit  pause_done;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: idle items, empty frames, the check string and extremes.
        add_row(8'h00, 1'b0, 1'b0, 1'b1, "");
        add_row(8'hA5, 1'b0, 1'b1, 1'b1, " *FFFF\r\n");
        add_row(8'hFF, 1'b0, 1'b0, 1'b1, "");
        for (int c = "1"; c <= "8"; c++) begin
            add_row(8'(c), 1'b1, 1'b0, 1'b1, $sformatf("%c", 8'(c)));
        end
        add_row("9", 1'b1, 1'b1, 1'b1, "9 *29B1\r\n");
        add_row(8'h00, 1'b1, 1'b0, 1'b0, "");
        add_row(8'hFF, 1'b1, 1'b1, 1'b0, "");
        add_row(8'h5A, 1'b0, 1'b1, 1'b1, " *FFFF\r\n");
        add_row(8'hFF, 1'b1, 1'b0, 1'b1, "\377");
        add_row(8'h80, 1'b1, 1'b0, 1'b0, "");
        add_row(8'h7F, 1'b1, 1'b1, 1'b0, "");
        add_row(8'h01, 1'b1, 1'b0, 1'b0, "");
        add_row(8'hFE, 1'b1, 1'b0, 1'b0, "");
        add_row(8'h00, 1'b0, 1'b0, 1'b0, "");
        add_row(8'h33, 1'b0, 1'b1, 1'b0, "");
        add_row(8'h00, 1'b1, 1'b1, 1'b0, "");
        foreach (directed_rows[k]) begin
            idle_gap();
            offer_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].golden);
        end

        // Random frames, with one long output hold-off, one drain pause and
        // a final stretch without idling.
        n_real     = 0;
        burst_left = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        while (n_real < RANDOM_ITEMS) begin
            if (n_real == 60 && !hold_done) begin
                hold_done  = 1'b1;
                hold_req   = 1'b1;
                burst_left = 24;
            end
            if (n_real == 100 && !pause_done) begin
                pause_done = 1'b1;
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (pending_bytes_q.size() != 0) @(negedge i_clk);
            end
            if (n_real >= 104) quiet = 1'b1;
            it = random_item();
            if (burst_left > 0) begin
                // Back-to-back payload transactions, mostly closing, to fill the queue.
                burst_left--;
                it.has_byte     = 1'b1;
                it.closes_frame = ($urandom_range(0, 3) != 0);
            end else begin
                idle_gap();
            end
            offer_item(it, 1'b0, "");
            if (it.has_byte || it.closes_frame) n_real++;
        end

        // Drain and finish.
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_bytes_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0 && pending_bytes_q.size() == 0) begin
            $display("tb_ascii_crc_frame_builder_top OK");
        end else begin
            $display("tb_ascii_crc_frame_builder_top NOT OK");
        end
        $finish;
    end

endmodule
